// ===== hdl/grid_localization_window_match_assert.svh =====
// Assertion macros shared by the grid localisation window match block.
// Depends on nothing; included by the top module, which carries the assertions.
`ifndef GRID_LOCALIZATION_WINDOW_MATCH_ASSERT_SVH
`define GRID_LOCALIZATION_WINDOW_MATCH_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define GLWM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GLWM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/glwm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the grid localisation window match block.
// Holds store sizes, action codes, heading codes and neighbour offsets.
package glwm_pkg;
	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int RowW = $clog2(MaxRows);
	localparam int ColW = $clog2(MaxCols);
	localparam int MazeDepth = MaxRows * MaxCols;
	localparam int MazeAw = RowW + ColW;
	localparam int CandCap = 4096;
	localparam int CandAw = $clog2(CandCap);
	localparam int CountW = CandAw + 1;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_OBS  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	localparam logic [1:0] HD_UP = 2'd0;
	localparam logic [1:0] HD_RIGHT = 2'd1;
	localparam logic [1:0] HD_DOWN = 2'd2;
	localparam logic [1:0] HD_LEFT = 2'd3;

	localparam logic [7:0] ChUp = 8'h5E;
	localparam logic [7:0] ChRight = 8'h3E;
	localparam logic [7:0] ChDown = 8'h76;
	localparam logic [7:0] ChFloor = 8'h2E;

	function automatic logic [1:0] heading_of(input logic [7:0] c);
		if (c == ChUp) return HD_UP;
		else if (c == ChRight) return HD_RIGHT;
		else if (c == ChDown) return HD_DOWN;
		return HD_LEFT;
	endfunction

	// Neighbour offsets in observation byte order, NW first, then clockwise.
	function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
		case (k)
			3'd0, 3'd6, 3'd7: return -2'sd1;
			3'd1, 3'd5: return 2'sd0;
			default: return 2'sd1;
		endcase
	endfunction

	function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
		case (k)
			3'd0, 3'd1, 3'd2: return -2'sd1;
			3'd3, 3'd7: return 2'sd0;
			default: return 2'sd1;
		endcase
	endfunction
endpackage

// ===== hdl/grid_localization_window_match.sv =====
`timescale 1ns / 1ps
// Top level of the grid localisation window match block.
// Uses glwm_pkg, glwm_ram and the assertion macro header.
//
//  channel  signals                                        direction
//  in       in_valid, in_stall, action..cand_index          into block
//  out      out_valid, out_stall, cand_count..cand_valid    out of block
//  config   psel, penable, pwrite, paddr, pwdata, prdata   APB, maze_rows at 0, maze_cols at 4
//
// An observation on an empty list scans every cell in use with one shared map read port;
// each cell takes the centre read and its check, nine neighbour slots and a decision.
// A move pass reads each candidate back, applies the move and checks its neighbours.
// The map read port sets the rate. Reset clears only the control state, the count, the
// heading, the result and the registers; the memories are not cleared.
// The input is stalled while a word is being worked on or a result waits to be taken.
module grid_localization_window_match
	import glwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [5:0]  cell_row,
	input  logic [5:0]  cell_col,
	input  logic [7:0]  cell_char,
	input  logic [63:0] obs_ring,
	input  logic [7:0]  center_char,
	input  logic [11:0] cand_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] cand_count,
	output logic [5:0]  cand_x,
	output logic [5:0]  cand_y,
	output logic [1:0]  cand_heading,
	output logic        cand_valid
);
	`include "grid_localization_window_match_assert.svh"

	localparam logic [2:0] AddrRows = 3'd0;
	localparam logic [2:0] AddrCols = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_RDOUT, ST_DECIDE,
		ST_CELL, ST_NB, ST_CHECK, ST_MREQ, ST_MWAIT, ST_MPOS, ST_DONE
	} state_t;

	state_t state_q;
	logic [6:0] rows_q, cols_q;
	logic [CountW-1:0] num_q, rd_q, wr_q;
	logic [1:0] heading_q;
	logic [63:0] ring_q;
	logic [CandAw-1:0] idx_q;
	logic [RowW-1:0] y_q;
	logic [ColW-1:0] x_q;
	logic [3:0] k_q;
	logic ok_q, scan_q;

	// Map memory
	logic maze_we;
	logic [MazeAw-1:0] maze_waddr, maze_raddr;
	logic [7:0] maze_wdata, maze_rdata;

	// Candidate memory
	logic cand_we;
	logic [CandAw-1:0] cand_waddr, cand_raddr;
	logic [MazeAw-1:0] cand_wdata, cand_rdata;

	glwm_ram #(.Width(8), .Depth(MazeDepth)) u_maze (
		.clk(clk), .we(maze_we), .waddr(maze_waddr), .wdata(maze_wdata),
		.raddr(maze_raddr), .rdata(maze_rdata));

	glwm_ram #(.Width(MazeAw), .Depth(CandCap)) u_cand (
		.clk(clk), .we(cand_we), .waddr(cand_waddr), .wdata(cand_wdata),
		.raddr(cand_raddr), .rdata(cand_rdata));

	// Rows and columns in use, clamped to the store size.
	logic [8:0] rows_u, cols_u;
	assign rows_u = (rows_q > 7'(MaxRows)) ? 9'(MaxRows) : {2'b0, rows_q};
	assign cols_u = (cols_q > 7'(MaxCols)) ? 9'(MaxCols) : {2'b0, cols_q};

	// Interior test for the current position.
	logic interior;
	assign interior = (x_q != '0) && (y_q != '0) && ({3'b0, x_q} + 9'd2 <= cols_u)
		&& ({3'b0, x_q} + 9'd2 < cols_u + 9'd0 + 9'd1) && ({3'b0, x_q} + 9'd1 < cols_u - 9'd0)
		&& ({3'b0, y_q} + 9'd2 < rows_u + 9'd1);

	// Neighbour address for step k (valid only when interior).
	logic [2:0] kk;
	logic [RowW-1:0] ny;
	logic [ColW-1:0] nx;
	assign kk = k_q[2:0];
	assign nx = x_q + ColW'(signed'(nb_dx(kk)));
	assign ny = y_q + RowW'(signed'(nb_dy(kk)));

	// Byte of the ring for the neighbour whose data returns now (k_q - 1).
	logic [2:0] kprev;
	logic [7:0] want;
	assign kprev = 3'(k_q - 4'd1);
	assign want = ring_q[{kprev, 3'b000} +: 8];

	// Position of a candidate read back from the candidate memory.
	logic [RowW-1:0] cy;
	logic [ColW-1:0] cx;
	assign cy = cand_rdata[MazeAw-1 -: RowW];
	assign cx = cand_rdata[ColW-1:0];

	always_comb begin
		maze_we = 1'b0;
		maze_waddr = {cell_row, cell_col};
		maze_wdata = cell_char;
		maze_raddr = {y_q, x_q};
		if (state_q == ST_IDLE && in_valid && action == ACT_LOAD) maze_we = 1'b1;
		if (state_q == ST_NB) maze_raddr = {ny, nx};
		cand_we = 1'b0;
		cand_waddr = wr_q[CandAw-1:0];
		cand_wdata = {y_q, x_q};
		cand_raddr = (state_q == ST_IDLE) ? cand_index : rd_q[CandAw-1:0];
		if (state_q == ST_CHECK && ok_q && (scan_q ? (wr_q < CountW'(CandCap)) : 1'b1))
			cand_we = 1'b1;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign prdata = (paddr == AddrRows) ? {25'b0, rows_q} :
		(paddr == AddrCols) ? {25'b0, cols_q} : 32'b0;
	assign cand_count = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= 7'd64;
			cols_q <= 7'd64;
			num_q <= '0;
			heading_q <= HD_UP;
			out_valid <= 1'b0;
			cand_x <= '0;
			cand_y <= '0;
			cand_heading <= HD_UP;
			cand_valid <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			x_q <= '0;
			y_q <= '0;
			k_q <= '0;
			ok_q <= 1'b0;
			scan_q <= 1'b0;
			idx_q <= '0;
			ring_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == AddrRows) rows_q <= pwdata[6:0];
				else if (paddr == AddrCols) cols_q <= pwdata[6:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cand_x <= '0;
						cand_y <= '0;
						cand_heading <= HD_UP;
						cand_valid <= 1'b0;
						ring_q <= obs_ring;
						idx_q <= cand_index;
						unique case (action)
							ACT_OBS: begin
								if (num_q == '0) begin
									heading_q <= heading_of(center_char);
									scan_q <= 1'b1;
									x_q <= '0;
									y_q <= '0;
									wr_q <= '0;
									state_q <= ST_CELL;
								end else if (heading_of(center_char) != heading_q) begin
									heading_q <= heading_of(center_char);
									state_q <= ST_DONE;
								end else begin
									scan_q <= 1'b0;
									rd_q <= '0;
									wr_q <= '0;
									state_q <= ST_MREQ;
								end
							end
							// The candidate memory is addressed by cand_index in this
							// cycle, so its data is there in the next one.
							ACT_READ: state_q <= ST_RDOUT;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RDOUT: begin
					if ({1'b0, idx_q} < num_q) begin
						cand_x <= cx;
						cand_y <= cy;
						cand_heading <= heading_q;
						cand_valid <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				// Scan: read the centre cell, then eight neighbours.
				ST_CELL: begin
					k_q <= '0;
					ok_q <= interior;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// centre data arrives now
					if (scan_q && maze_rdata != ChFloor) ok_q <= 1'b0;
					state_q <= ST_NB;
				end
				ST_NB: begin
					if (k_q != '0 && maze_rdata != want) ok_q <= 1'b0;
					if (k_q == 4'd8) state_q <= ST_CHECK;
					k_q <= k_q + 4'd1;
				end
				ST_CHECK: begin
					if (cand_we) wr_q <= wr_q + 1'b1;
					if (scan_q) begin
						if ({3'b0, x_q} + 9'd1 >= cols_u) begin
							x_q <= '0;
							if ({3'b0, y_q} + 9'd1 >= rows_u) begin
								num_q <= wr_q + CountW'(cand_we);
								state_q <= ST_DONE;
							end else begin
								y_q <= y_q + 1'b1;
								state_q <= ST_CELL;
							end
						end else begin
							x_q <= x_q + 1'b1;
							state_q <= ST_CELL;
						end
					end else begin
						rd_q <= rd_q + 1'b1;
						if (rd_q + 1'b1 >= num_q) begin
							num_q <= wr_q + CountW'(cand_we);
							state_q <= ST_DONE;
						end else state_q <= ST_MREQ;
					end
				end
				ST_MREQ: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					// Apply the move; a step off the store edge wraps to position 0 or to the last position,
					// both of which the interior test rejects.
					x_q <= cx;
					y_q <= cy;
					ok_q <= 1'b1;
					if (heading_q == HD_RIGHT) x_q <= (cx == '1) ? '0 : cx + 1'b1;
					if (heading_q == HD_LEFT) x_q <= cx - 1'b1;
					if (heading_q == HD_DOWN) y_q <= (cy == '1) ? '0 : cy + 1'b1;
					if (heading_q == HD_UP) y_q <= cy - 1'b1;
					state_q <= ST_MPOS;
				end
				ST_MPOS: begin
					k_q <= '0;
					ok_q <= interior;
					state_q <= ST_NB;
				end
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`GLWM_ASSERT_IMP(a_count_cap, 1'b1, num_q <= 13'(CandCap))
	`GLWM_ASSERT_IMP(a_busy_no_out, out_valid, in_stall)
	`GLWM_ASSERT_NXT(a_read_valid, state_q == ST_RDOUT && {1'b0, idx_q} >= num_q, !cand_valid)
endmodule

// ===== hdl/glwm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, one-read-port RAM with registered read data.
// No dependencies.
module glwm_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
